// ----- rtl/core/finito_logistic_step_engine_unit_assert.svh -----
// Assertion macros for the Finito logistic step engine.
// Taken in by the top level; no other dependencies.
`ifndef FINITO_LOGISTIC_STEP_ENGINE_UNIT_ASSERT_SVH
`define FINITO_LOGISTIC_STEP_ENGINE_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define FLSE_ASSERT_IMP(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define FLSE_ASSERT_NXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define FLSE_ASSERT_IMP(name, clk, rst, ante, cons, msg)
`define FLSE_ASSERT_NXT(name, clk, rst, ante, cons, msg)
`endif
`endif

// ----- rtl/core/flse_pkg.sv -----
// Shared types, constants and helper functions of the Finito logistic step engine.
// Holds the sigmoid table, built at elaboration; depends on nothing.
package flse_pkg;

   localparam int MAX_ROWS_DEF    = 1024;
   localparam int MAX_DIM_DEF     = 64;
   localparam int SIGMOID_ENTRIES = 256;

   // shared multiplier operand and product widths
   localparam int MUL_W  = 34;
   localparam int PROD_W = 2 * MUL_W;
   localparam int SIG_W  = 17;
   // sigmoid input range limit, 8.0 in Q16.16
   localparam int SIG_LIM = 8 << 16;

   localparam int CMD_W       = 3;
   localparam int CSR_IDX_W   = 3;
   localparam int REQ_TDATA_W = 56;
   localparam int RSP_TDATA_W = 40;

   // command codes
   localparam logic [CMD_W-1:0] CMD_WR_FEATURE = 3'd0;
   localparam logic [CMD_W-1:0] CMD_WR_LABEL   = 3'd1;
   localparam logic [CMD_W-1:0] CMD_INIT       = 3'd2;
   localparam logic [CMD_W-1:0] CMD_STEP       = 3'd3;
   localparam logic [CMD_W-1:0] CMD_RD_MEAN    = 3'd4;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DIMS      = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_ROWS  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_REG_STR   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_ALPHA = 3'd4;

   typedef enum logic [4:0] {
      ST_IDLE, ST_DECODE, ST_RD_WAIT,
      ST_I_COL, ST_I_ADDR, ST_I_P, ST_I_G, ST_I_A, ST_I_Z, ST_I_W,
      ST_I_MLO, ST_I_MHI, ST_I_MW,
      ST_S_LAB, ST_S_DADDR, ST_S_DMUL, ST_S_DACC, ST_S_SIG, ST_S_SIGW,
      ST_S_UADDR, ST_S_UP, ST_S_UR, ST_S_UG, ST_S_UA, ST_S_UZ, ST_S_UD, ST_S_UM,
      ST_DONE
   } flse_state_type;

   typedef logic [SIG_W-1:0] sig_table_type [SIGMOID_ENTRIES];

   localparam logic signed [71:0] SAT_HI = 72'sd2147483647;
   localparam logic signed [71:0] SAT_LO = -72'sd2147483648;

   // clamp to the signed 32-bit range
   function automatic logic signed [31:0] sat32(input logic signed [71:0] v);
      if (v > SAT_HI) return 32'sh7FFFFFFF;
      if (v < SAT_LO) return 32'sh80000000;
      return v[31:0];
   endfunction

   // restoring division, used only while building the table
   function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] q;
      logic [63:0] rem;
      q   = '0;
      rem = '0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[62:0], num[i]};
         if (rem >= den) begin
            rem  = rem - den;
            q[i] = 1'b1;
         end
      end
      return q;
   endfunction

   // exp(-f) in Q2.30 by a 21-term series
   function automatic logic [63:0] exp_neg_q30(input logic [63:0] f);
      logic signed [63:0] sum;
      logic [63:0]        term;
      sum  = 64'sd1 <<< 30;
      term = 64'd1 << 30;
      for (int k = 1; k <= 20; k++) begin
         term = udiv64((term * f) >> 30, 64'(k));
         if (k % 2 == 1) sum = sum - $signed(term);
         else sum = sum + $signed(term);
      end
      return (sum < 0) ? 64'd0 : 64'(sum);
   endfunction

   function automatic sig_table_type build_sig_table();
      sig_table_type tbl;
      logic [63:0]   e1;
      logic [63:0]   num;
      logic [63:0]   mag;
      logic [63:0]   a;
      logic [63:0]   ip;
      logic [63:0]   e;
      logic [63:0]   sp;
      logic          neg;
      e1 = exp_neg_q30(64'd1 << 30);
      for (int k = 0; k < SIGMOID_ENTRIES; k++) begin
         num = 64'(2 * k + 1);
         neg = num < 64'(SIGMOID_ENTRIES);
         mag = neg ? 64'(SIGMOID_ENTRIES) - num : num - 64'(SIGMOID_ENTRIES);
         a   = ((mag * 64'd8) << 30) / SIGMOID_ENTRIES;
         ip  = a >> 30;
         e   = exp_neg_q30(a & ((64'd1 << 30) - 64'd1));
         for (longint unsigned i = 0; i < ip; i++) e = (e * e1) >> 30;
         sp  = udiv64(64'd1 << 46, (64'd1 << 30) + e);
         tbl[k] = neg ? SIG_W'(64'd65536 - sp) : SIG_W'(sp);
      end
      return tbl;
   endfunction

   localparam sig_table_type SIG_TABLE = build_sig_table();
   // sigmoid of zero
   localparam logic [SIG_W-1:0] SIG_ZERO = SIG_TABLE[SIGMOID_ENTRIES / 2];

endpackage

// ----- rtl/core/flse_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module flse_ram #(
   parameter int WIDTH  = 32,
   parameter int ADDR_W = 10
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [1 << ADDR_W];
   logic [WIDTH-1:0] rdata_ff;

   // write port, registered read port
   always_ff @(posedge clock) begin
      if (we) mem_ff[waddr] <= wdata;
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/core/flse_mul.sv -----
// Shared signed multiplier with a registered product.
// Depends on flse_pkg for operand widths.
module flse_mul (
   input  logic                               clock,
   input  logic signed [flse_pkg::MUL_W-1:0]  a,
   input  logic signed [flse_pkg::MUL_W-1:0]  b,
   output logic signed [flse_pkg::PROD_W-1:0] prod
);

   logic signed [flse_pkg::PROD_W-1:0] prod_ff;

   // register every product
   always_ff @(posedge clock) begin
      prod_ff <= flse_pkg::PROD_W'(a) * flse_pkg::PROD_W'(b);
   end

   assign prod = prod_ff;

endmodule

// ----- rtl/core/flse_sig.sv -----
// Saturating sigmoid lookup over [-8,8) with a registered result.
// Depends on flse_pkg for the table and its size.
module flse_sig #(
   parameter int ACC_W = 59
) (
   input  logic                                clock,
   input  logic signed [ACC_W-1:0]             arg,
   output logic        [flse_pkg::SIG_W-1:0]   sig
);

   localparam int IDX_W = $clog2(flse_pkg::SIGMOID_ENTRIES);
   localparam int SC_W  = 21 + IDX_W;
   localparam logic signed [ACC_W-1:0] LIM_POS = ACC_W'(flse_pkg::SIG_LIM);
   localparam logic signed [ACC_W-1:0] LIM_NEG = -LIM_POS;

   logic signed [ACC_W-1:0]      off;
   logic        [SC_W-1:0]       scaled;
   logic        [IDX_W-1:0]      idx;
   logic        [flse_pkg::SIG_W-1:0] sig_in;
   logic        [flse_pkg::SIG_W-1:0] sig_ff;

   // scale the offset argument to a table index, clamp outside the range
   always_comb begin
      off    = arg + LIM_POS;
      scaled = SC_W'(off[19:0]) * SC_W'(flse_pkg::SIGMOID_ENTRIES);
      idx    = scaled[19+IDX_W:20];
      if (arg < LIM_NEG) sig_in = flse_pkg::SIG_TABLE[0];
      else if (arg >= LIM_POS) sig_in = flse_pkg::SIG_TABLE[flse_pkg::SIGMOID_ENTRIES-1];
      else sig_in = flse_pkg::SIG_TABLE[idx];
   end

   always_ff @(posedge clock) begin
      sig_ff <= sig_in;
   end

   assign sig = sig_ff;

endmodule

// ----- rtl/core/finito_logistic_step_engine_unit.sv -----
// Channel | Dir | Payload
// req_    | in  | tuser: command[2:0]; tdata: row[9:0] col[15:10] value[47:16] label[48]
// rsp_    | out | tdata: read_value[31:0] status[32]
// csr_    | in  | index[2:0] data[30:0]: rows, dims, inv_rows, reg_strength, inv_alpha_s
// A write or a reject passes through DECODE and DONE before rsp_tvalid rises; a mean read also passes RD_WAIT.
// A step runs the dot product per column (DADDR, DMUL, DACC, one multiplier pass), a sigmoid lookup, then
// the update per column (UADDR to UM, four multiplier passes), all on one shared multiplier.
// Initialize walks every column over every row, one multiplier pass per product.
// Reset is synchronous, clears the mean (valid bits) and sets the configuration registers to their defaults.
// The next item is accepted while a finished result still waits in the output register.
// Top level of the Finito logistic step engine; uses flse_pkg, flse_ram, flse_mul, flse_sig.
`include "finito_logistic_step_engine_unit_assert.svh"
module finito_logistic_step_engine_unit #(
   parameter int MAX_ROWS = flse_pkg::MAX_ROWS_DEF,
   parameter int MAX_DIM  = flse_pkg::MAX_DIM_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // row[9:0], col[15:10], value[47:16], label[48], zero fill
   input  logic [flse_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // command[2:0]
   input  logic [flse_pkg::CMD_W-1:0]          req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // read_value[31:0], status[32], zero fill
   output logic [flse_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [flse_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [31:0]                         csr_data
);

   localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int DIM_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int RCNT_W = $clog2(MAX_ROWS + 1);
   localparam int DCNT_W = $clog2(MAX_DIM + 1);
   localparam int ACC_W  = 49 + ((ROW_W > DIM_W) ? ROW_W : DIM_W);
   localparam int FA_W   = ROW_W + DIM_W;
   localparam int MEAN_DEPTH = 1 << DIM_W;
   localparam int MUL_W  = flse_pkg::MUL_W;
   localparam int PROD_W = flse_pkg::PROD_W;

   flse_pkg::flse_state_type state_ff, state_in;

   // configuration registers
   logic [10:0] rows_ff;
   logic [6:0]  dims_ff;
   logic [16:0] inv_rows_ff;
   logic [30:0] reg_str_ff;
   logic [30:0] inv_alpha_ff;

   // latched transaction
   logic [flse_pkg::CMD_W-1:0] cmd_ff, cmd_in;
   logic [9:0]          row_ff, row_in;
   logic [5:0]          col_ff, col_in;
   logic signed [31:0]  value_ff, value_in;
   logic                label_ff, label_in;

   // working registers
   logic [RCNT_W-1:0]        r_ff, r_in;
   logic [DCNT_W-1:0]        j_ff, j_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic [flse_pkg::SIG_W-1:0] g_ff, g_in;
   logic signed [31:0]       m_ff, m_in;
   logic signed [31:0]       old_ff, old_in;
   logic signed [MUL_W-1:0]  p_ff, p_in;
   logic signed [31:0]       t_ff, t_in;
   logic signed [PROD_W-1:0] lo_ff, lo_in;
   logic                     pos_ff, pos_in;
   logic signed [31:0]       res_value_ff, res_value_in;
   logic                     res_status_ff, res_status_in;
   logic                     mrd_valid_ff;
   logic [MEAN_DEPTH-1:0]    mean_valid_ff;

   // output register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [31:0]       rsp_value_ff, rsp_value_in;
   logic                     rsp_status_ff, rsp_status_in;

   // memory and unit controls
   logic             feat_we, label_we, sv_we, mean_we, mean_clear, rsp_load;
   logic [FA_W-1:0]  feat_waddr, feat_raddr, sv_addr;
   logic [31:0]      feat_wdata, feat_rd, sv_wdata, sv_rd, mean_wdata, mean_rd;
   logic [ROW_W-1:0] label_waddr, label_raddr;
   logic             label_rd;
   logic [DIM_W-1:0] mean_waddr, mean_raddr;
   logic signed [MUL_W-1:0]  mul_a, mul_b;
   logic signed [PROD_W-1:0] prod, prod_f16;
   logic signed [ACC_W-1:0]  sig_arg;
   logic [flse_pkg::SIG_W-1:0] sig_out;

   logic [RCNT_W-1:0]  nr;
   logic [DCNT_W-1:0]  nd;
   logic               row_ok, col_ok;
   logic signed [31:0] m_sel;
   logic signed [32:0] z_diff;
   logic [FA_W-1:0]    step_addr, init_addr;

   // effective sizes and range checks
   always_comb begin
      nr = (32'(rows_ff) < 32'(MAX_ROWS)) ? RCNT_W'(rows_ff) : RCNT_W'(MAX_ROWS);
      nd = (32'(dims_ff) < 32'(MAX_DIM)) ? DCNT_W'(dims_ff) : DCNT_W'(MAX_DIM);
      row_ok    = 32'(row_ff) < 32'(nr);
      col_ok    = 32'(col_ff) < 32'(nd);
      prod_f16  = prod >>> 16;
      m_sel     = mrd_valid_ff ? $signed(mean_rd) : 32'sd0;
      z_diff    = 33'(t_ff) - 33'(old_ff);
      sig_arg   = pos_ff ? -acc_ff : acc_ff;
      step_addr = {ROW_W'(row_ff), j_ff[DIM_W-1:0]};
      init_addr = {r_ff[ROW_W-1:0], j_ff[DIM_W-1:0]};
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         flse_pkg::ST_IDLE:    if (req_tvalid) state_in = flse_pkg::ST_DECODE;
         flse_pkg::ST_DECODE: begin
            case (cmd_ff)
               flse_pkg::CMD_INIT:    state_in = flse_pkg::ST_I_COL;
               flse_pkg::CMD_STEP:    state_in = row_ok ? flse_pkg::ST_S_LAB : flse_pkg::ST_DONE;
               flse_pkg::CMD_RD_MEAN: state_in = col_ok ? flse_pkg::ST_RD_WAIT : flse_pkg::ST_DONE;
               default:               state_in = flse_pkg::ST_DONE;
            endcase
         end
         flse_pkg::ST_RD_WAIT: state_in = flse_pkg::ST_DONE;
         flse_pkg::ST_I_COL:   state_in = (j_ff < nd) ? flse_pkg::ST_I_ADDR : flse_pkg::ST_DONE;
         flse_pkg::ST_I_ADDR:  state_in = (r_ff < nr) ? flse_pkg::ST_I_P : flse_pkg::ST_I_MLO;
         flse_pkg::ST_I_P:     state_in = flse_pkg::ST_I_G;
         flse_pkg::ST_I_G:     state_in = flse_pkg::ST_I_A;
         flse_pkg::ST_I_A:     state_in = flse_pkg::ST_I_Z;
         flse_pkg::ST_I_Z:     state_in = flse_pkg::ST_I_W;
         flse_pkg::ST_I_W:     state_in = flse_pkg::ST_I_ADDR;
         flse_pkg::ST_I_MLO:   state_in = flse_pkg::ST_I_MHI;
         flse_pkg::ST_I_MHI:   state_in = flse_pkg::ST_I_MW;
         flse_pkg::ST_I_MW:    state_in = flse_pkg::ST_I_COL;
         flse_pkg::ST_S_LAB:   state_in = flse_pkg::ST_S_DADDR;
         flse_pkg::ST_S_DADDR: state_in = (j_ff < nd) ? flse_pkg::ST_S_DMUL : flse_pkg::ST_S_SIG;
         flse_pkg::ST_S_DMUL:  state_in = flse_pkg::ST_S_DACC;
         flse_pkg::ST_S_DACC:  state_in = flse_pkg::ST_S_DADDR;
         flse_pkg::ST_S_SIG:   state_in = flse_pkg::ST_S_SIGW;
         flse_pkg::ST_S_SIGW:  state_in = flse_pkg::ST_S_UADDR;
         flse_pkg::ST_S_UADDR: state_in = (j_ff < nd) ? flse_pkg::ST_S_UP : flse_pkg::ST_DONE;
         flse_pkg::ST_S_UP:    state_in = flse_pkg::ST_S_UR;
         flse_pkg::ST_S_UR:    state_in = flse_pkg::ST_S_UG;
         flse_pkg::ST_S_UG:    state_in = flse_pkg::ST_S_UA;
         flse_pkg::ST_S_UA:    state_in = flse_pkg::ST_S_UZ;
         flse_pkg::ST_S_UZ:    state_in = flse_pkg::ST_S_UD;
         flse_pkg::ST_S_UD:    state_in = flse_pkg::ST_S_UM;
         flse_pkg::ST_S_UM:    state_in = flse_pkg::ST_S_UADDR;
         flse_pkg::ST_DONE:    if (!rsp_valid_ff || rsp_tready) state_in = flse_pkg::ST_IDLE;
         default:              state_in = flse_pkg::ST_IDLE;
      endcase
   end

   // memory ports, multiplier operands and handshakes
   always_comb begin
      req_tready  = (state_ff == flse_pkg::ST_IDLE);
      csr_ready   = 1'b1;
      feat_we     = 1'b0;
      feat_waddr  = {ROW_W'(row_ff), DIM_W'(col_ff)};
      feat_wdata  = value_ff;
      feat_raddr  = step_addr;
      label_we    = 1'b0;
      label_waddr = ROW_W'(row_ff);
      label_raddr = ROW_W'(row_ff);
      sv_we       = 1'b0;
      sv_addr     = step_addr;
      sv_wdata    = t_ff;
      mean_we     = 1'b0;
      mean_clear  = 1'b0;
      mean_waddr  = j_ff[DIM_W-1:0];
      mean_wdata  = m_ff;
      mean_raddr  = j_ff[DIM_W-1:0];
      mul_a       = '0;
      mul_b       = '0;
      rsp_load    = 1'b0;
      case (state_ff)
         flse_pkg::ST_DECODE: begin
            feat_we    = (cmd_ff == flse_pkg::CMD_WR_FEATURE) && row_ok && col_ok;
            label_we   = (cmd_ff == flse_pkg::CMD_WR_LABEL) && row_ok;
            mean_clear = (cmd_ff == flse_pkg::CMD_INIT);
            mean_raddr = DIM_W'(col_ff);
         end
         flse_pkg::ST_I_ADDR: begin
            feat_raddr  = init_addr;
            label_raddr = r_ff[ROW_W-1:0];
         end
         flse_pkg::ST_I_P: begin
            mul_a = MUL_W'({1'b0, flse_pkg::SIG_ZERO});
            mul_b = MUL_W'($signed(feat_rd));
         end
         flse_pkg::ST_I_A, flse_pkg::ST_S_UA: begin
            mul_a = MUL_W'({1'b0, inv_alpha_ff});
            mul_b = MUL_W'(t_ff);
         end
         flse_pkg::ST_I_W: begin
            sv_we   = 1'b1;
            sv_addr = init_addr;
         end
         flse_pkg::ST_I_MLO: begin
            mul_a = MUL_W'({1'b0, acc_ff[15:0]});
            mul_b = MUL_W'({1'b0, inv_rows_ff});
         end
         flse_pkg::ST_I_MHI: begin
            mul_a = MUL_W'(acc_ff >>> 16);
            mul_b = MUL_W'({1'b0, inv_rows_ff});
         end
         flse_pkg::ST_I_MW: begin
            mean_we    = 1'b1;
            mean_wdata = flse_pkg::sat32(72'(prod) + 72'(lo_ff));
         end
         flse_pkg::ST_S_DMUL: begin
            mul_a = MUL_W'(m_sel);
            mul_b = MUL_W'($signed(feat_rd));
         end
         flse_pkg::ST_S_UP: begin
            mul_a = MUL_W'({1'b0, g_ff});
            mul_b = MUL_W'($signed(feat_rd));
         end
         flse_pkg::ST_S_UR: begin
            mul_a = MUL_W'({1'b0, reg_str_ff});
            mul_b = MUL_W'(m_ff);
         end
         flse_pkg::ST_S_UD: begin
            sv_we = 1'b1;
            mul_a = MUL_W'(z_diff);
            mul_b = MUL_W'({1'b0, inv_rows_ff});
         end
         flse_pkg::ST_S_UM: begin
            mean_we    = 1'b1;
            mean_wdata = flse_pkg::sat32(72'(m_ff) + 72'(prod_f16));
         end
         flse_pkg::ST_DONE: rsp_load = !rsp_valid_ff || rsp_tready;
         default: ;
      endcase
   end

   // datapath registers
   always_comb begin
      cmd_in        = cmd_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      value_in      = value_ff;
      label_in      = label_ff;
      r_in          = r_ff;
      j_in          = j_ff;
      acc_in        = acc_ff;
      g_in          = g_ff;
      m_in          = m_ff;
      old_in        = old_ff;
      p_in          = p_ff;
      t_in          = t_ff;
      lo_in         = lo_ff;
      pos_in        = pos_ff;
      res_value_in  = res_value_ff;
      res_status_in = res_status_ff;
      case (state_ff)
         flse_pkg::ST_IDLE: begin
            cmd_in   = req_tuser;
            row_in   = req_tdata[9:0];
            col_in   = req_tdata[15:10];
            value_in = $signed(req_tdata[47:16]);
            label_in = req_tdata[48];
         end
         flse_pkg::ST_DECODE: begin
            res_value_in = '0;
            j_in         = '0;
            case (cmd_ff)
               flse_pkg::CMD_WR_FEATURE: res_status_in = !(row_ok && col_ok);
               flse_pkg::CMD_WR_LABEL:   res_status_in = !row_ok;
               flse_pkg::CMD_INIT:       res_status_in = 1'b0;
               flse_pkg::CMD_STEP:       res_status_in = !row_ok;
               flse_pkg::CMD_RD_MEAN:    res_status_in = !col_ok;
               default:                  res_status_in = 1'b1;
            endcase
         end
         flse_pkg::ST_RD_WAIT: res_value_in = m_sel;
         flse_pkg::ST_I_COL: begin
            r_in   = '0;
            acc_in = '0;
         end
         flse_pkg::ST_I_P:  pos_in = label_rd;
         flse_pkg::ST_I_G:
            t_in = pos_ff ? flse_pkg::sat32(-72'(prod_f16)) : flse_pkg::sat32(72'(prod_f16));
         flse_pkg::ST_I_Z:  t_in = flse_pkg::sat32(-72'(prod_f16));
         flse_pkg::ST_I_W: begin
            acc_in = acc_ff + ACC_W'(t_ff);
            r_in   = RCNT_W'(r_ff + 1'b1);
         end
         flse_pkg::ST_I_MHI: lo_in = prod >>> 16;
         flse_pkg::ST_I_MW:  j_in = DCNT_W'(j_ff + 1'b1);
         flse_pkg::ST_S_LAB: begin
            pos_in = label_rd;
            acc_in = '0;
         end
         flse_pkg::ST_S_DACC: begin
            acc_in = acc_ff + ACC_W'(prod_f16);
            j_in   = DCNT_W'(j_ff + 1'b1);
         end
         flse_pkg::ST_S_SIGW: begin
            g_in = sig_out;
            j_in = '0;
         end
         flse_pkg::ST_S_UP: begin
            m_in   = m_sel;
            old_in = $signed(sv_rd);
         end
         flse_pkg::ST_S_UR: p_in = MUL_W'(prod_f16);
         flse_pkg::ST_S_UG:
            t_in = pos_ff ? flse_pkg::sat32(72'(prod_f16) - 72'(p_ff))
                          : flse_pkg::sat32(72'(prod_f16) + 72'(p_ff));
         flse_pkg::ST_S_UZ: t_in = flse_pkg::sat32(72'(m_ff) - 72'(prod_f16));
         flse_pkg::ST_S_UM: j_in = DCNT_W'(j_ff + 1'b1);
         default: ;
      endcase
   end

   // output register: load the result, drop it when taken
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_value_in  = res_value_ff;
         rsp_status_in = res_status_ff;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= flse_pkg::ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         mean_valid_ff <= '0;
         rows_ff       <= 11'd1;
         dims_ff       <= 7'd1;
         inv_rows_ff   <= 17'd65536;
         reg_str_ff    <= '0;
         inv_alpha_ff  <= 31'd65536;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (mean_clear) mean_valid_ff <= '0;
         else if (mean_we) mean_valid_ff[mean_waddr] <= 1'b1;
         if (csr_valid) begin
            case (csr_index)
               flse_pkg::CSR_ROWS:      rows_ff      <= csr_data[10:0];
               flse_pkg::CSR_DIMS:      dims_ff      <= csr_data[6:0];
               flse_pkg::CSR_INV_ROWS:  inv_rows_ff  <= csr_data[16:0];
               flse_pkg::CSR_REG_STR:   reg_str_ff   <= csr_data[30:0];
               flse_pkg::CSR_INV_ALPHA: inv_alpha_ff <= csr_data[30:0];
               default: ;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      row_ff        <= row_in;
      col_ff        <= col_in;
      value_ff      <= value_in;
      label_ff      <= label_in;
      r_ff          <= r_in;
      j_ff          <= j_in;
      acc_ff        <= acc_in;
      g_ff          <= g_in;
      m_ff          <= m_in;
      old_ff        <= old_in;
      p_ff          <= p_in;
      t_ff          <= t_in;
      lo_ff         <= lo_in;
      pos_ff        <= pos_in;
      res_value_ff  <= res_value_in;
      res_status_ff <= res_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      mrd_valid_ff  <= mean_valid_ff[mean_raddr];
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_status_ff, rsp_value_ff};

   flse_ram #(.WIDTH(32), .ADDR_W(FA_W)) u_feat_ram (
      .clock(clock), .we(feat_we), .waddr(feat_waddr), .wdata(feat_wdata),
      .raddr(feat_raddr), .rdata(feat_rd)
   );

   flse_ram #(.WIDTH(1), .ADDR_W(ROW_W)) u_label_ram (
      .clock(clock), .we(label_we), .waddr(label_waddr), .wdata(label_ff),
      .raddr(label_raddr), .rdata(label_rd)
   );

   flse_ram #(.WIDTH(32), .ADDR_W(FA_W)) u_sv_ram (
      .clock(clock), .we(sv_we), .waddr(sv_addr), .wdata(sv_wdata),
      .raddr(sv_addr), .rdata(sv_rd)
   );

   flse_ram #(.WIDTH(32), .ADDR_W(DIM_W)) u_mean_ram (
      .clock(clock), .we(mean_we), .waddr(mean_waddr), .wdata(mean_wdata),
      .raddr(mean_raddr), .rdata(mean_rd)
   );

   flse_mul u_mul (
      .clock(clock), .a(mul_a), .b(mul_b), .prod(prod)
   );

   flse_sig #(.ACC_W(ACC_W)) u_sig (
      .clock(clock), .arg(sig_arg), .sig(sig_out)
   );

   // checks
   `FLSE_ASSERT_NXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready, "input taken while busy")
   `FLSE_ASSERT_IMP(a_mean_write_state, clock, reset, mean_we, state_ff == flse_pkg::ST_I_MW || state_ff == flse_pkg::ST_S_UM, "mean written outside update")
   `FLSE_ASSERT_IMP(a_reject_zero, clock, reset, rsp_tvalid && rsp_tdata[32], rsp_tdata[31:0] == 32'd0, "rejected result carries data")
   `FLSE_ASSERT_NXT(a_result_loaded, clock, reset, rsp_load, rsp_tvalid, "finished result not presented")

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the Finito logistic step engine: directed table, then phased
// random traffic checked against a cycle-free predictor of the engine's fixed-point maths.
// Depends on flse_pkg and finito_logistic_step_engine_unit.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int  N_ROWS     = 1024;
   localparam int  N_DIM      = 64;
   localparam int  ITEM_GOAL  = 1550;
   localparam int  CYCLE_CAP  = 16000000;
   localparam int  DRAIN_WAIT = 12;

   localparam int REQ_TDATA_W     = flse_pkg::REQ_TDATA_W;
   localparam int RSP_TDATA_W     = flse_pkg::RSP_TDATA_W;
   localparam int CMD_W           = flse_pkg::CMD_W;
   localparam int CSR_IDX_W       = flse_pkg::CSR_IDX_W;
   localparam int SIGMOID_ENTRIES = flse_pkg::SIGMOID_ENTRIES;
   localparam logic [CMD_W-1:0] CMD_WR_FEATURE = flse_pkg::CMD_WR_FEATURE;
   localparam logic [CMD_W-1:0] CMD_WR_LABEL   = flse_pkg::CMD_WR_LABEL;
   localparam logic [CMD_W-1:0] CMD_INIT       = flse_pkg::CMD_INIT;
   localparam logic [CMD_W-1:0] CMD_STEP       = flse_pkg::CMD_STEP;
   localparam logic [CMD_W-1:0] CMD_RD_MEAN    = flse_pkg::CMD_RD_MEAN;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS      = flse_pkg::CSR_ROWS;
   localparam logic [CSR_IDX_W-1:0] CSR_DIMS      = flse_pkg::CSR_DIMS;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_ROWS  = flse_pkg::CSR_INV_ROWS;
   localparam logic [CSR_IDX_W-1:0] CSR_REG_STR   = flse_pkg::CSR_REG_STR;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_ALPHA = flse_pkg::CSR_INV_ALPHA;

   typedef struct {
      logic [31:0] rd_val;
      logic        status;
   } rsp_item_type;

   typedef struct packed {
      logic [2:0]  cmd;
      logic [9:0]  row;
      logic [5:0]  col;
      logic [31:0] val;
      logic        lab;
      logic        typed;
      logic [31:0] ev;
      logic        es;
   } dir_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic [CMD_W-1:0]       req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index = '0;
   logic [31:0]            csr_data = '0;

   // predictor state
   longint    sig_lut [SIGMOID_ENTRIES];
   int        feat_mem [N_ROWS*N_DIM];
   int        zvec_mem [N_ROWS*N_DIM];
   bit        lab_mem [N_ROWS];
   int        mean_mem [N_DIM];
   longint    cfg_rows, cfg_dims, cfg_inv_rows, cfg_reg, cfg_inv_alpha;

   rsp_item_type pending_rsp[$];
   int        err_cnt = 0;
   int        cycle_cnt = 0;
   int        item_cnt = 0;
   bit        calm = 1'b0;
   int        rsp_hold = 0;
   dir_row_type dir_tbl [25];

   finito_logistic_step_engine_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // bound the run
   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt > CYCLE_CAP) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (calm || r < 55) return 0;
      if (r < 92) return $urandom_range(3, 1);
      return $urandom_range(40, 8);
   endfunction

   function automatic longint fl16(longint v);
      return v >>> 16;
   endfunction

   function automatic longint clamp32(longint v);
      if (v > 64'sd2147483647) return 64'sd2147483647;
      if (v < -64'sd2147483648) return -64'sd2147483648;
      return v;
   endfunction

   // exp(-f), f in Q2.30, by a truncated power series
   function automatic longint unsigned exp_series(longint unsigned f);
      longint          acc;
      longint unsigned term;
      acc  = 64'sd1 <<< 30;
      term = 64'd1 << 30;
      for (int k = 1; k <= 20; k++) begin
         term = ((term * f) >> 30) / longint'(k);
         if (k % 2 == 1) acc = acc - longint'(term);
         else acc = acc + longint'(term);
      end
      return (acc < 0) ? 64'd0 : longint'(acc);
   endfunction

   // sigmoid at the midpoint of each interval over [-8,8)
   task automatic fill_sig_lut();
      longint unsigned e1, num, mag, a, ip, e, sp;
      bit              neg;
      e1 = exp_series(64'd1 << 30);
      for (int k = 0; k < SIGMOID_ENTRIES; k++) begin
         num = 64'(2 * k + 1);
         neg = num < 64'(SIGMOID_ENTRIES);
         mag = neg ? 64'(SIGMOID_ENTRIES) - num : num - 64'(SIGMOID_ENTRIES);
         a   = ((mag * 64'd8) << 30) / 64'(SIGMOID_ENTRIES);
         ip  = a >> 30;
         e   = exp_series(a & ((64'd1 << 30) - 64'd1));
         for (longint unsigned i = 0; i < ip; i++) e = (e * e1) >> 30;
         sp  = (64'd1 << 46) / ((64'd1 << 30) + e);
         sig_lut[k] = neg ? 64'sd65536 - longint'(sp) : longint'(sp);
      end
   endtask

   function automatic longint sig_of(longint t);
      longint lim;
      lim = 64'sd8 <<< 16;
      if (t < -lim) return sig_lut[0];
      if (t >= lim) return sig_lut[SIGMOID_ENTRIES-1];
      return sig_lut[((t + lim) * SIGMOID_ENTRIES) >>> 20];
   endfunction

   function automatic int rows_eff();
      return (cfg_rows < N_ROWS) ? int'(cfg_rows) : N_ROWS;
   endfunction

   function automatic int dims_eff();
      return (cfg_dims < N_DIM) ? int'(cfg_dims) : N_DIM;
   endfunction

   // advance the predicted engine by one command and return its response
   task automatic engine_apply(input logic [2:0] cmd, input int row, input int col,
                               input logic [31:0] val, input logic lab,
                               output rsp_item_type res);
      int     nr, nd, base;
      longint d, g, m, p, grad, nz, inc, acc, z;
      bit     pos;
      nr = rows_eff();
      nd = dims_eff();
      res.rd_val = '0;
      res.status = 1'b0;
      case (cmd)
         CMD_WR_FEATURE: begin
            if (row < nr && col < nd) feat_mem[row*N_DIM + col] = int'($signed(val));
            else res.status = 1'b1;
         end
         CMD_WR_LABEL: begin
            if (row < nr) lab_mem[row] = lab;
            else res.status = 1'b1;
         end
         CMD_INIT: begin
            g = sig_of(0);
            foreach (mean_mem[j]) mean_mem[j] = 0;
            for (int j = 0; j < nd; j++) begin
               acc = 0;
               for (int r = 0; r < nr; r++) begin
                  p    = fl16(g * longint'(feat_mem[r*N_DIM + j]));
                  grad = clamp32(lab_mem[r] ? -p : p);
                  z    = clamp32(-fl16(cfg_inv_alpha * grad));
                  zvec_mem[r*N_DIM + j] = int'(z);
                  acc += z;
               end
               mean_mem[j] = int'(clamp32(fl16(acc * cfg_inv_rows)));
            end
         end
         CMD_STEP: begin
            if (row < nr) begin
               base = row * N_DIM;
               pos  = lab_mem[row];
               d    = 0;
               for (int j = 0; j < nd; j++)
                  d += fl16(longint'(mean_mem[j]) * longint'(feat_mem[base + j]));
               g = sig_of(pos ? -d : d);
               for (int j = 0; j < nd; j++) begin
                  m    = mean_mem[j];
                  p    = fl16(g * longint'(feat_mem[base + j]));
                  grad = clamp32(fl16(cfg_reg * m) - (pos ? p : -p));
                  nz   = clamp32(m - fl16(cfg_inv_alpha * grad));
                  inc  = fl16((nz - longint'(zvec_mem[base + j])) * cfg_inv_rows);
                  zvec_mem[base + j] = int'(nz);
                  mean_mem[j] = int'(clamp32(m + inc));
               end
            end else res.status = 1'b1;
         end
         CMD_RD_MEAN: begin
            if (col < nd) res.rd_val = mean_mem[col];
            else res.status = 1'b1;
         end
         default: res.status = 1'b1;
      endcase
   endtask

   // offer one request; predict on acceptance
   task automatic send_req(input logic [2:0] cmd, input int row, input int col,
                           input logic [31:0] val, input logic lab,
                           input bit typed, input rsp_item_type typed_rsp);
      int           gap;
      rsp_item_type res;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = cmd;
      req_tdata  = {7'b0, lab, val, 6'(col), 10'(row)};
      forever begin
         @(posedge clock);
         if (req_tready) break;
      end
      engine_apply(cmd, row, col, val, lab, res);
      pending_rsp.push_back(typed ? typed_rsp : res);
      item_cnt++;
      @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [31:0] data);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = data;
      forever begin
         @(posedge clock);
         if (csr_ready) break;
      end
      case (idx)
         CSR_ROWS:      cfg_rows      = data & 32'h7FF;
         CSR_DIMS:      cfg_dims      = data & 32'h7F;
         CSR_INV_ROWS:  cfg_inv_rows  = data & 32'h1FFFF;
         CSR_REG_STR:   cfg_reg       = data & 32'h7FFFFFFF;
         CSR_INV_ALPHA: cfg_inv_alpha = data & 32'h7FFFFFFF;
         default: ;
      endcase
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // hold until every response is back and the engine has settled
   task automatic drain();
      req_tvalid = 1'b0;
      while (pending_rsp.size() != 0) @(negedge clock);
      repeat (DRAIN_WAIT) @(negedge clock);
   endtask

   function automatic logic [31:0] pick_value();
      int r;
      r = $urandom_range(99);
      if (r < 10) begin
         case ($urandom_range(4))
            0: return 32'h7FFFFFFF;
            1: return 32'h80000000;
            2: return 32'h0;
            3: return 32'h1;
            default: return 32'hFFFFFFFF;
         endcase
      end
      if (r < 30) return $urandom;
      if (r < 70) return 32'($signed($urandom_range(32'h40000)) - 32'sh20000);
      return 32'($signed($urandom_range(32'h600000)) - 32'sh300000);
   endfunction

   function automatic int pick_row(int nr);
      if (nr > 0 && (nr >= N_ROWS || $urandom_range(99) < 85)) return $urandom_range(nr - 1);
      if (nr >= N_ROWS) return $urandom_range(N_ROWS - 1);
      return $urandom_range(N_ROWS - 1, nr);
   endfunction

   function automatic int pick_col(int nd);
      if (nd > 0 && (nd >= N_DIM || $urandom_range(99) < 85)) return $urandom_range(nd - 1);
      if (nd >= N_DIM) return $urandom_range(N_DIM - 1);
      return $urandom_range(N_DIM - 1, nd);
   endfunction

   // one phase: program, load every sample and initialise when they fit, then mixed traffic
   task automatic run_phase(input int p, input int n_ops);
      logic [31:0]  rows_w, dims_w, ir_w, rs_w, ia_w;
      int           nr, nd, r, row, col;
      bit           can_run;
      rsp_item_type none;
      none = '{rd_val: '0, status: 1'b0};
      case (p)
         1: begin rows_w = 3; dims_w = 2; ir_w = 21845; rs_w = 0; ia_w = 65536; end
         2: begin rows_w = 2; dims_w = 64; ir_w = 65536; rs_w = 32'h7FFFFFFF;
                  ia_w = 32'h7FFFFFFF; end
         3: begin rows_w = 0; dims_w = 0; ir_w = 65536; rs_w = 1000; ia_w = 1; end
         4: begin rows_w = 2047; dims_w = 127; ir_w = 0; rs_w = 0; ia_w = 0; end
         5: begin rows_w = 5; dims_w = 3; ir_w = 0; rs_w = $urandom_range(65536);
                  ia_w = $urandom_range(1 << 20); end
         6: begin rows_w = 1024; dims_w = 1; ir_w = 64; rs_w = 0; ia_w = 65536; end
         default: begin
            rows_w = $urandom_range(12, 1);
            dims_w = $urandom_range(8, 1);
            ir_w   = (65536 / rows_w) + $urandom_range(3);
            rs_w   = ($urandom_range(3) == 0) ? $urandom : $urandom_range(1 << 15);
            ia_w   = ($urandom_range(3) == 0) ? $urandom : $urandom_range(1 << 19);
         end
      endcase
      write_csr(CSR_ROWS, rows_w);
      write_csr(CSR_DIMS, dims_w);
      write_csr(CSR_INV_ROWS, ir_w);
      write_csr(CSR_REG_STR, rs_w);
      write_csr(CSR_INV_ALPHA, ia_w);
      nr = rows_eff();
      nd = dims_eff();
      // too many samples to load: skip loading and init, send steps only to rows out of range
      can_run = (nr * (nd + 1) <= 200);
      if (can_run) begin
         for (int i = 0; i < nr; i++) begin
            for (int j = 0; j < nd; j++)
               send_req(CMD_WR_FEATURE, i, j, pick_value(), 1'b0, 1'b0, none);
            send_req(CMD_WR_LABEL, i, 0, $urandom, 1'($urandom), 1'b0, none);
         end
         send_req(CMD_INIT, $urandom_range(N_ROWS - 1), $urandom_range(N_DIM - 1),
                  $urandom, 1'($urandom), 1'b0, none);
      end
      for (int k = 0; k < n_ops; k++) begin
         r   = $urandom_range(99);
         row = pick_row(nr);
         col = pick_col(nd);
         if (r < 35 && (can_run || row >= nr))
            send_req(CMD_STEP, row, $urandom_range(N_DIM - 1), $urandom, 1'($urandom),
                     1'b0, none);
         else if (r < 58 || (r < 35))
            send_req(CMD_RD_MEAN, $urandom_range(N_ROWS - 1), col, $urandom, 1'($urandom),
                     1'b0, none);
         else if (r < 78)
            send_req(CMD_WR_FEATURE, row, col, pick_value(), 1'($urandom), 1'b0, none);
         else if (r < 88)
            send_req(CMD_WR_LABEL, row, $urandom_range(N_DIM - 1), $urandom, 1'($urandom),
                     1'b0, none);
         else if (r < 94 && can_run)
            send_req(CMD_INIT, $urandom_range(N_ROWS - 1), $urandom_range(N_DIM - 1),
                     $urandom, 1'($urandom), 1'b0, none);
         else
            send_req(CMD_RD_MEAN + 3'($urandom_range(3, 1)), $urandom_range(N_ROWS - 1),
                     $urandom_range(N_DIM - 1), $urandom, 1'($urandom), 1'b0, none);
      end
      drain();
   endtask

   // response checker: compare each transaction with the oldest prediction
   initial begin
      rsp_item_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            if (pending_rsp.size() == 0) begin
               $display("%0t: unexpected response %h", $time, rsp_tdata);
               err_cnt++;
            end else begin
               want = pending_rsp.pop_front();
               if (rsp_tdata[31:0] !== want.rd_val) begin
                  $display("%0t: read_value expected %h actual %h", $time, want.rd_val,
                           rsp_tdata[31:0]);
                  err_cnt++;
               end
               if (rsp_tdata[32] !== want.status) begin
                  $display("%0t: status expected %b actual %b", $time, want.status,
                           rsp_tdata[32]);
                  err_cnt++;
               end
            end
         end
      end
   end

   // response back-pressure
   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_tready <= 1'b0;
         rsp_hold   <= rsp_hold - 1;
      end else begin
         rsp_tready <= 1'b1;
         if ($urandom_range(3) == 0) rsp_hold <= pick_gap();
      end
   end

   initial begin
      rsp_item_type typed_rsp;
      int           p;
      fill_sig_lut();
      cfg_rows = 1; cfg_dims = 1; cfg_inv_rows = 65536; cfg_reg = 0; cfg_inv_alpha = 65536;
      foreach (mean_mem[j]) mean_mem[j] = 0;
      // directed cases: bounds, extremes of value, every command, unknown commands
      dir_tbl = '{
         '{CMD_RD_MEAN,    10'd0,    6'd0,  32'h0,        1'b0, 1'b1, 32'h0, 1'b0},
         '{CMD_RD_MEAN,    10'd0,    6'd63, 32'h0,        1'b0, 1'b1, 32'h0, 1'b1},
         '{CMD_RD_MEAN,    10'd1023, 6'd1,  32'hFFFFFFFF, 1'b1, 1'b1, 32'h0, 1'b1},
         '{CMD_WR_FEATURE, 10'd0,    6'd0,  32'h7FFFFFFF, 1'b0, 1'b1, 32'h0, 1'b0},
         '{CMD_WR_FEATURE, 10'd1,    6'd0,  32'h1,        1'b0, 1'b1, 32'h0, 1'b1},
         '{CMD_WR_FEATURE, 10'd0,    6'd1,  32'h1,        1'b0, 1'b1, 32'h0, 1'b1},
         '{CMD_WR_FEATURE, 10'd1023, 6'd63, 32'h80000000, 1'b1, 1'b1, 32'h0, 1'b1},
         '{CMD_WR_LABEL,   10'd0,    6'd0,  32'h0,        1'b1, 1'b1, 32'h0, 1'b0},
         '{CMD_WR_LABEL,   10'd1023, 6'd0,  32'h0,        1'b0, 1'b1, 32'h0, 1'b1},
         '{3'd5,           10'd0,    6'd0,  32'h0,        1'b0, 1'b1, 32'h0, 1'b1},
         '{3'd6,           10'd0,    6'd0,  32'h0,        1'b0, 1'b1, 32'h0, 1'b1},
         '{3'd7,           10'd0,    6'd0,  32'h0,        1'b0, 1'b1, 32'h0, 1'b1},
         '{CMD_STEP,       10'd1,    6'd0,  32'h0,        1'b0, 1'b1, 32'h0, 1'b1},
         '{CMD_INIT,       10'd0,    6'd0,  32'h0,        1'b0, 1'b1, 32'h0, 1'b0},
         '{CMD_RD_MEAN,    10'd0,    6'd0,  32'h0,        1'b0, 1'b0, 32'h0, 1'b0},
         '{CMD_STEP,       10'd0,    6'd0,  32'h0,        1'b0, 1'b1, 32'h0, 1'b0},
         '{CMD_RD_MEAN,    10'd0,    6'd0,  32'h0,        1'b0, 1'b0, 32'h0, 1'b0},
         '{CMD_WR_FEATURE, 10'd0,    6'd0,  32'h80000000, 1'b0, 1'b1, 32'h0, 1'b0},
         '{CMD_WR_LABEL,   10'd0,    6'd0,  32'h0,        1'b0, 1'b1, 32'h0, 1'b0},
         '{CMD_INIT,       10'd0,    6'd0,  32'h0,        1'b0, 1'b1, 32'h0, 1'b0},
         '{CMD_STEP,       10'd0,    6'd0,  32'h0,        1'b0, 1'b0, 32'h0, 1'b0},
         '{CMD_RD_MEAN,    10'd0,    6'd0,  32'h0,        1'b0, 1'b0, 32'h0, 1'b0},
         '{CMD_WR_FEATURE, 10'd0,    6'd0,  32'h00010000, 1'b0, 1'b0, 32'h0, 1'b0},
         '{CMD_STEP,       10'd0,    6'd0,  32'h0,        1'b0, 1'b0, 32'h0, 1'b0},
         '{CMD_RD_MEAN,    10'd0,    6'd0,  32'h0,        1'b0, 1'b0, 32'h0, 1'b0}
      };
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      foreach (dir_tbl[i]) begin
         typed_rsp.rd_val = dir_tbl[i].ev;
         typed_rsp.status = dir_tbl[i].es;
         send_req(dir_tbl[i].cmd, dir_tbl[i].row, dir_tbl[i].col, dir_tbl[i].val,
                  dir_tbl[i].lab, dir_tbl[i].typed, typed_rsp);
      end
      drain();
      // random phases, the extreme settings first
      p = 1;
      while (item_cnt < ITEM_GOAL) begin
         calm = ($urandom_range(3) == 0);
         run_phase(p, (p == 2) ? 40 : 100);
         p++;
      end
      drain();
      if (err_cnt == 0) $display("== PASS ==");
      else $display("== FAIL ==");
      $finish;
   end

endmodule
